// File: rtl/bcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcm_pkg;

	// Fixed field widths of the item formats
	localparam int unsigned SLOT_FIELD_W = 6;
	localparam int unsigned TAG_FIELD_W  = 48;
	localparam int unsigned LEN_W        = 5;
	localparam int unsigned LIMIT_W      = 5;
	localparam int unsigned BASE_W       = 3;

	// Widest tag that any MAX_BASES setting can hold (21 bases)
	localparam int unsigned TAG_PAD_W    = 63;

	localparam int unsigned TABLE_ENTRIES_DEF = 64;
	localparam int unsigned MAX_BASES_DEF     = 16;

	localparam logic [BASE_W-1:0] BASE_N = 3'd4;

	// Item kinds
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Register indexes
	localparam logic REG_LIMIT = 1'b0;
	localparam logic REG_WILD  = 1'b1;

	typedef struct packed {
		logic [LIMIT_W-1:0] mismatch_limit;
		logic               wildcard_enable;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/dual_barcode_table_matcher.sv
`timescale 1ns / 1ps
`default_nettype none

// Dual barcode table matcher.
// Input stream (s_*): tuser carries the kind, load or query. A load writes one
// table slot and gives no result; a load to a slot beyond
// the table is dropped. A query is compared with the table one entry per
// cycle through one shared entry comparator fed from the table RAM's
// registered read port, and gives exactly one result item on m_*: tuser is
// the found flag, tdata the lowest matching slot (zero when nothing matches).
// The scan reads the entries in slot order from slot 0 and stops at the first
// match or after the last entry (at most TABLE_ENTRIES entries).
// After a load the next item is taken on the following cycle; after a query
// s_tready stays low until its result has entered the output register.
// s_tready is high whenever no query is under way, so an item is accepted
// even while a result waits in the output register. A finished query whose
// result cannot yet leave holds until m_tready drains the output register.
// Configuration: cfg_we writes register cfg_index with cfg_data. The user must
// write only while the block is idle; the block itself does not enforce this.
// Reset: all table entries become invalid at once, mismatch_limit returns to
// zero and wildcard_enable to one; no clearing pass is needed.
module dual_barcode_table_matcher #(
	parameter int unsigned TABLE_ENTRIES = bcm_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned MAX_BASES     = bcm_pkg::MAX_BASES_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	// Input items
	input  wire          s_tvalid,
	output logic         s_tready,
	// [5:0] entry_slot, [53:6] first_tag_bases, [58:54] first_tag_length,
	// [106:59] second_tag_bases, [111:107] second_tag_length
	input  wire  [111:0] s_tdata,
	// [0] opcode
	input  wire  [0:0]   s_tuser,
	// Result items
	output logic         m_tvalid,
	input  wire          m_tready,
	// [5:0] matched_slot, [7:6] zero
	output logic [7:0]   m_tdata,
	// [0] found
	output logic [0:0]   m_tuser,
	// Configuration writes
	input  wire          cfg_we,
	input  wire  [0:0]   cfg_index,
	input  wire  [4:0]   cfg_data
);

	import bcm_pkg::*;

	localparam int unsigned SLOT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned TAG_W   = BASE_W * MAX_BASES;
	localparam int unsigned ENTRY_W = 2 * TAG_W + 2 * LEN_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);
	localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(MAX_BASES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PUSH = 3'b100
	} state_t;

	state_t state_q;

	// Unpack the input item
	logic [SLOT_FIELD_W-1:0] in_slot;
	logic [TAG_W-1:0]        in_t1;
	logic [TAG_W-1:0]        in_t2;
	logic [LEN_W-1:0]        in_l1_raw;
	logic [LEN_W-1:0]        in_l2_raw;
	logic [LEN_W-1:0]        in_l1;
	logic [LEN_W-1:0]        in_l2;
	logic [TAG_PAD_W-1:0]    pad_t1;
	logic [TAG_PAD_W-1:0]    pad_t2;

	assign in_slot   = s_tdata[5:0];
	assign pad_t1    = {{(TAG_PAD_W-TAG_FIELD_W){1'b0}}, s_tdata[53:6]};
	assign in_l1_raw = s_tdata[58:54];
	assign pad_t2    = {{(TAG_PAD_W-TAG_FIELD_W){1'b0}}, s_tdata[106:59]};
	assign in_l2_raw = s_tdata[111:107];
	// Bases past the field width read as zero, as a wide tag would hold them
	assign in_t1     = pad_t1[TAG_W-1:0];
	assign in_t2     = pad_t2[TAG_W-1:0];
	// Saturate lengths above the table's tag size
	assign in_l1     = (in_l1_raw > LEN_MAX) ? LEN_MAX : in_l1_raw;
	assign in_l2     = (in_l2_raw > LEN_MAX) ? LEN_MAX : in_l2_raw;

	logic in_fire;
	logic load_fire;
	logic query_fire;
	logic slot_in_range;

	assign s_tready      = (state_q == ST_IDLE);
	assign in_fire       = s_tvalid && s_tready;
	assign load_fire     = in_fire && (s_tuser[0] == OP_LOAD);
	assign query_fire    = in_fire && (s_tuser[0] == OP_QUERY);
	assign slot_in_range = (32'(in_slot) < TABLE_ENTRIES);

	// Configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mismatch_limit  <= '0;
			cfg_q.wildcard_enable <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index[0])
				REG_LIMIT: cfg_q.mismatch_limit  <= cfg_data;
				REG_WILD:  cfg_q.wildcard_enable <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// Table: tags and lengths in RAM, valid bits in flops cleared by reset
	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	logic [SLOT_W-1:0]        waddr;
	logic [SLOT_W-1:0]        scan_addr_q;
	logic [ENTRY_W-1:0]       ram_rdata;

	assign waddr = SLOT_W'(in_slot);

	bcm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (load_fire && slot_in_range),
		.waddr (waddr),
		.wdata ({in_l2, in_l1, in_t2, in_t1}),
		.raddr (scan_addr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (load_fire && slot_in_range) begin
			entry_valid_q[waddr] <= 1'b1;
		end
	end

	// Query held for the whole scan
	logic [TAG_W-1:0] qry_t1_q;
	logic [TAG_W-1:0] qry_t2_q;
	logic [LEN_W-1:0] qry_l1_q;
	logic [LEN_W-1:0] qry_l2_q;

	always_ff @(posedge clk) begin
		if (query_fire) begin
			qry_t1_q <= in_t1;
			qry_t2_q <= in_t2;
			qry_l1_q <= in_l1;
			qry_l2_q <= in_l2;
		end
	end

	// Shared entry comparator on the registered RAM output
	logic match;

	bcm_entry_cmp #(
		.MAX_BASES (MAX_BASES)
	) u_cmp (
		.cfg      (cfg_q),
		.query_t1 (qry_t1_q),
		.query_t2 (qry_t2_q),
		.query_l1 (qry_l1_q),
		.query_l2 (qry_l2_q),
		.entry_t1 (ram_rdata[TAG_W-1:0]),
		.entry_t2 (ram_rdata[2*TAG_W-1:TAG_W]),
		.entry_l1 (ram_rdata[2*TAG_W +: LEN_W]),
		.entry_l2 (ram_rdata[2*TAG_W+LEN_W +: LEN_W]),
		.match    (match)
	);

	// Scan sequencer: issue one read per cycle, test each entry on the RAM's registered read data
	logic              issued_last_q;
	logic              rd_vld_s1;
	logic              ev_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              hit;
	logic              scan_done;
	logic              issue;
	logic              res_found_q;
	logic [SLOT_W-1:0] res_slot_q;

	assign hit       = rd_vld_s1 && ev_s1 && match;
	assign scan_done = hit || (rd_vld_s1 && (slot_s1 == LAST_SLOT));
	assign issue     = (state_q == ST_SCAN) && !issued_last_q && !scan_done;

	// Output register
	logic              m_tvalid_q;
	logic              m_found_q;
	logic [SLOT_W-1:0] m_slot_q;
	logic              out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_addr_q   <= '0;
			issued_last_q <= 1'b0;
			rd_vld_s1     <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			// Load a finished result, else drop the item once taken
			if (state_q == ST_PUSH && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (query_fire) begin
						scan_addr_q   <= '0;
						issued_last_q <= 1'b0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issued_last_q <= (scan_addr_q == LAST_SLOT);
						scan_addr_q   <= scan_addr_q + 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					// Hold the result until the output register drains
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ev_s1   <= entry_valid_q[scan_addr_q];
		slot_s1 <= scan_addr_q;
		if (state_q == ST_SCAN && scan_done) begin
			res_found_q <= hit;
			res_slot_q  <= hit ? slot_s1 : '0;
		end
		if (state_q == ST_PUSH && out_free) begin
			m_found_q <= res_found_q;
			m_slot_q  <= res_slot_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tuser[0] = m_found_q;
	assign m_tdata    = {2'b00, SLOT_FIELD_W'(m_slot_q)};

endmodule

`default_nettype wire

// File: rtl/bcm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire                                        clk,
	input  wire                                        we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                           wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/bcm_entry_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module bcm_entry_cmp #(
	parameter int unsigned MAX_BASES = 16
) (
	input  wire  bcm_pkg::cfg_t          cfg,
	input  wire  [3*MAX_BASES-1:0]       query_t1,
	input  wire  [3*MAX_BASES-1:0]       query_t2,
	input  wire  [bcm_pkg::LEN_W-1:0]    query_l1,
	input  wire  [bcm_pkg::LEN_W-1:0]    query_l2,
	input  wire  [3*MAX_BASES-1:0]       entry_t1,
	input  wire  [3*MAX_BASES-1:0]       entry_t2,
	input  wire  [bcm_pkg::LEN_W-1:0]    entry_l1,
	input  wire  [bcm_pkg::LEN_W-1:0]    entry_l2,
	output logic                         match
);

	import bcm_pkg::*;

	logic [MAX_BASES-1:0] miss1;
	logic [MAX_BASES-1:0] miss2;
	logic [LEN_W:0]       cnt1;
	logic [LEN_W:0]       cnt2;
	logic [LEN_W:0]       limit_x;
	logic                 ok1;
	logic                 ok2;

	always_comb begin
		for (int i = 0; i < MAX_BASES; i++) begin
			miss1[i] = (LEN_W'(i) < entry_l1) &&
				!((entry_t1[BASE_W*i +: BASE_W] == query_t1[BASE_W*i +: BASE_W]) ||
				  (cfg.wildcard_enable && query_t1[BASE_W*i +: BASE_W] == BASE_N));
			miss2[i] = (LEN_W'(i) < entry_l2) &&
				!((entry_t2[BASE_W*i +: BASE_W] == query_t2[BASE_W*i +: BASE_W]) ||
				  (cfg.wildcard_enable && query_t2[BASE_W*i +: BASE_W] == BASE_N));
		end
		cnt1    = (LEN_W+1)'($countones(miss1));
		cnt2    = (LEN_W+1)'($countones(miss2));
		limit_x = {1'b0, cfg.mismatch_limit};
		ok1     = (cnt1 <= limit_x);
		ok2     = (cnt2 <= limit_x);
		// Skip the second tag for single-index entries
		match   = (query_l1 >= entry_l1) && (query_l2 >= entry_l2) && ok1 &&
			((entry_l2 == '0) || ok2);
	end

endmodule

`default_nettype wire
